### design/aligned_stack_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// aligned stack allocator assertion macros
// shared property wrappers for the allocator checks, clocked on clk and
// disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ALIGNED_STACK_ALLOCATOR_UNIT_DEFINES_SVH
`define ALIGNED_STACK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define ASAU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/asau_pkg.sv
// ----------------------------------------------------------------------------
// asau_pkg
// types, constants and helpers shared by the stack allocator modules
// ----------------------------------------------------------------------------
package asau_pkg;

	localparam int ARENA_BYTES     = 65536;
	localparam int MAX_ENTRIES_DEF = 64;
	localparam int HEADER_BYTES    = 16;
	localparam int HEADER_ALIGN    = 8;

	localparam int CAP_W  = 17;
	localparam int SUM_W  = 18;
	localparam int PAD_W  = 7;
	localparam int HPAD_W = 4;

	localparam logic [HPAD_W-1:0] HPAD_MASK = HPAD_W'(HEADER_ALIGN - 1);

	// register indexes on the config port (paddr[2])
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_BASE     = 1'b1;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_POP   = 2'd1,
		ACT_TOP   = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP1,
		ST_STEP2
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step1;
		logic commit;
	} asau_cmd_t;

	typedef struct packed {
		logic out_free;
	} asau_sts_t;

	typedef struct packed {
		logic [15:0]       size;
		logic [7:0]        pad;
		logic [HPAD_W-1:0] hpad;
	} hdr_t;

	// alignment minus one, from the highest set bit; zero acts as one
	function automatic logic [PAD_W-1:0] align_mask(input logic [7:0] a);
		logic [PAD_W-1:0] m;
		m = '0;
		for (int i = 1; i < 8; i++) begin
			if (a[i]) m = PAD_W'((8'd1 << i) - 8'd1);
		end
		return m;
	endfunction

	function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
		return (c > CAP_W'(ARENA_BYTES)) ? CAP_W'(ARENA_BYTES) : c;
	endfunction

endpackage

### design/aligned_stack_allocator_unit.sv
// ----------------------------------------------------------------------------
// aligned_stack_allocator_unit
// lifo arena allocator with aligned data and per-allocation headers
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  tuser: action; tdata: block_size, alignment
//  m_*      out  m_tvalid / m_tready  tdata: address, status, bytes_used, flags
//  apb      in   psel & penable       capacity at 0x0, base at 0x4
//
//  each item passes through accept, then an alignment step with the header stack
//  read, then the commit step that writes the offset, the stack and the result
//  register. the commit waits while the previous result is still held, so a
//  new item can be accepted while an earlier result sits unread.
//  reset clears the used offset, the entry count and the result valid flag;
//  the header stack has no reset, only entries below the count are read.
// ----------------------------------------------------------------------------
`include "aligned_stack_allocator_unit_defines.svh"

module aligned_stack_allocator_unit #(
	parameter int MAX_ENTRIES = asau_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // block_size[15:0], alignment[23:16]
	input  logic [1:0]  s_tuser,  // action[1:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // address[31:0], status[33:32], bytes_used[50:34],
	                              // is_empty[51], is_full[52], zero[55:53]
);
	import asau_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic [31:0]      base_q;
	logic             cfg_wr;

	asau_cmd_t cmd;
	asau_sts_t sts;

	logic [31:0]      address;
	logic [1:0]       status;
	logic [CAP_W-1:0] bytes_used;
	logic             is_empty;
	logic             is_full;

	// config registers, to be written only while the unit is idle; the block does not enforce it
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(ARENA_BYTES);
			base_q     <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_CAPACITY: capacity_q <= pwdata[CAP_W-1:0];
				REG_BASE:     base_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CAPACITY: prdata = 32'(capacity_q);
			REG_BASE:     prdata = base_q;
			default:      prdata = '0;
		endcase
	end

	// sequencer
	asau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// offset, header stack and result register
	asau_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (s_tuser),
		.block_size (s_tdata[15:0]),
		.alignment  (s_tdata[23:16]),
		.capacity   (capacity_q),
		.base       (base_q),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.address    (address),
		.status     (status),
		.bytes_used (bytes_used),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	assign m_tdata = {3'b000, is_full, is_empty, bytes_used, status, address};

	// one item in flight: an accept drops ready for the next cycle
	`ASAU_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item taken early")
	// commit never overwrites a result that has not been taken
	`ASAU_ASSERT_NOW(a_commit_free, cmd.commit, !m_tvalid || m_tready, "result overwritten")
	// a result appears only after a commit
	`ASAU_ASSERT_NOW(a_valid_src, $rose(m_tvalid), $past(cmd.commit), "result without commit")

endmodule

### design/asau_ctrl.sv
// ----------------------------------------------------------------------------
// asau_ctrl
// sequencer: accept an item, run the two datapath steps, hand off the result
// ----------------------------------------------------------------------------
module asau_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  asau_pkg::asau_sts_t sts,
	output asau_pkg::asau_cmd_t cmd
);
	import asau_pkg::*;

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_STEP1;
			end
			ST_STEP1: state_nxt = ST_STEP2;
			ST_STEP2: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_STEP1: cmd.step1 = 1'b1;
			ST_STEP2: cmd.commit = sts.out_free;
			default: ;
		endcase
	end

endmodule

### design/asau_dp.sv
// ----------------------------------------------------------------------------
// asau_dp
// offset and count registers, header stack memory, alignment arithmetic
// and the result register
// ----------------------------------------------------------------------------
module asau_dp #(
	parameter int MAX_ENTRIES = asau_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  asau_pkg::asau_cmd_t        cmd,
	output asau_pkg::asau_sts_t        sts,
	input  logic [1:0]                 action,
	input  logic [15:0]                block_size,
	input  logic [7:0]                 alignment,
	input  logic [asau_pkg::CAP_W-1:0] capacity,
	input  logic [31:0]                base,
	input  logic                       m_tready,
	output logic                       m_tvalid,
	output logic [31:0]                address,
	output logic [1:0]                 status,
	output logic [asau_pkg::CAP_W-1:0] bytes_used,
	output logic                       is_empty,
	output logic                       is_full
);
	import asau_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	hdr_t mem [MAX_ENTRIES];

	action_t          act_q;
	logic [15:0]      size_q;
	logic [PAD_W-1:0] mask_q;
	logic [CAP_W-1:0] used_q;
	logic [CNT_W-1:0] count_q;
	hdr_t             rd_q;

	logic [PAD_W-1:0] pad_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [31:0]      addr_s1;
	logic             reject_s1;

	logic             m_tvalid_q;
	logic [31:0]      out_addr_q;
	status_t          out_status_q;
	logic [CAP_W-1:0] out_used_q;
	logic             out_empty_q;
	logic             out_full_q;

	logic [CAP_W-1:0] cap_eff;
	logic [CNT_W-1:0] cnt_m1;
	logic [PAD_W-1:0] pad_low;
	logic [HPAD_W-1:0] hpad;
	logic [SUM_W-1:0] total;
	logic [SUM_W-1:0] span;
	logic             alloc_ok;
	logic [CAP_W-1:0] used_nxt;
	logic [CNT_W-1:0] count_nxt;
	logic [31:0]      addr_nxt;
	status_t          status_nxt;

	assign cap_eff = eff_cap(capacity);
	assign cnt_m1  = count_q - 1'b1;
	assign pad_low = base[PAD_W-1:0] + used_q[PAD_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action_t'(action);
			size_q <= block_size;
			mask_q <= align_mask(alignment);
		end
		if (cmd.step1) begin
			pad_s1    <= (PAD_W'(0) - pad_low) & mask_q;
			sum_s1    <= SUM_W'(used_q) + SUM_W'((PAD_W'(0) - pad_low) & mask_q)
				+ SUM_W'(size_q);
			addr_s1   <= base + 32'(used_q) + 32'((PAD_W'(0) - pad_low) & mask_q);
			reject_s1 <= (used_q == cap_eff) || (count_q >= MAX_CNT);
		end
	end

	// header stack: top entry read every cycle, pushed on a good allocate
	always_ff @(posedge clk) begin
		rd_q <= mem[cnt_m1[IDX_W-1:0]];
		if (cmd.commit && act_q == ACT_ALLOC && alloc_ok)
			mem[count_q[IDX_W-1:0]] <= '{size: size_q, pad: 8'(pad_s1), hpad: hpad};
	end

	always_comb begin
		hpad     = (HPAD_W'(0) - (base[HPAD_W-1:0] + sum_s1[HPAD_W-1:0])) & HPAD_MASK;
		total    = sum_s1 + SUM_W'(HEADER_BYTES) + SUM_W'(hpad);
		alloc_ok = !reject_s1 && (total <= SUM_W'(cap_eff));
		span     = SUM_W'(rd_q.size) + SUM_W'(rd_q.pad) + SUM_W'(rd_q.hpad)
			+ SUM_W'(HEADER_BYTES);

		used_nxt   = used_q;
		count_nxt  = count_q;
		addr_nxt   = '0;
		status_nxt = STS_OK;
		case (act_q)
			ACT_ALLOC: begin
				if (alloc_ok) begin
					used_nxt  = total[CAP_W-1:0];
					count_nxt = count_q + 1'b1;
					addr_nxt  = addr_s1;
				end else begin
					status_nxt = STS_FULL;
				end
			end
			ACT_POP: begin
				if (count_q == '0 || used_q == '0) begin
					status_nxt = STS_EMPTY;
				end else begin
					used_nxt  = (span > SUM_W'(used_q)) ? '0 : used_q - span[CAP_W-1:0];
					count_nxt = cnt_m1;
				end
			end
			ACT_TOP: begin
				if (count_q == '0) status_nxt = STS_EMPTY;
				else addr_nxt = base + 32'(used_q) - 32'(HEADER_BYTES) - 32'(rd_q.hpad)
					- 32'(rd_q.size);
			end
			ACT_CLEAR: begin
				used_nxt  = '0;
				count_nxt = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				used_q     <= used_nxt;
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_addr_q   <= addr_nxt;
			out_status_q <= status_nxt;
			out_used_q   <= used_nxt;
			out_empty_q  <= (used_nxt == '0);
			out_full_q   <= (used_nxt == cap_eff);
		end
	end

	assign sts.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid     = m_tvalid_q;
	assign address      = out_addr_q;
	assign status       = out_status_q;
	assign bytes_used   = out_used_q;
	assign is_empty     = out_empty_q;
	assign is_full      = out_full_q;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the aligned stack allocator: a directed item list,
// then random phases under several capacity and base settings, every result
// compared against a fixed value from the list or an arena predictor kept in the testbench
// ----------------------------------------------------------------------------
module tb_top;
	import asau_pkg::*;

	localparam int MAX_BLOCKS     = MAX_ENTRIES_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PRINT_LIMIT    = 40;

	// one result item as the predictor sees it
	typedef struct packed {
		logic [31:0] address;
		status_t     status;
		logic [16:0] used;
		logic        empty;
		logic        full;
	} alloc_result_t;

	// one row of the directed list; want is only used when typed is set
	typedef struct packed {
		action_t       act;
		logic [15:0]   size;
		logic [7:0]    align;
		logic          typed;
		alloc_result_t want;
	} probe_row_t;

	// register setting and item mix of one random phase
	typedef struct packed {
		logic [16:0] cap;
		logic [31:0] base;
		int unsigned items;
		int unsigned alloc_pct;
		int unsigned big_pct;
	} arena_phase_t;

	localparam alloc_result_t NO_CHECK = '{32'd0, STS_OK, 17'd0, 1'b0, 1'b0};

	localparam int DIRECTED_ROWS = 23;
	localparam probe_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		// top and pop on an empty arena
		'{ACT_TOP,   16'd0,     8'd1,   1'b1, '{32'd0, STS_EMPTY, 17'd0,     1'b1, 1'b0}},
		'{ACT_POP,   16'd0,     8'd1,   1'b1, '{32'd0, STS_EMPTY, 17'd0,     1'b1, 1'b0}},
		// zero size with zero alignment: just a header
		'{ACT_ALLOC, 16'd0,     8'd0,   1'b1, '{32'd0, STS_OK,    17'd16,    1'b0, 1'b0}},
		// largest alignment, then a non power of two alignment
		'{ACT_ALLOC, 16'd1,     8'd128, 1'b0, NO_CHECK},
		'{ACT_TOP,   16'd0,     8'd0,   1'b0, NO_CHECK},
		'{ACT_ALLOC, 16'd5,     8'd3,   1'b0, NO_CHECK},
		// largest size and all alignment bits set: overflow
		'{ACT_ALLOC, 16'hFFFF,  8'hFF,  1'b0, NO_CHECK},
		'{ACT_ALLOC, 16'h5555,  8'h40,  1'b0, NO_CHECK},
		'{ACT_ALLOC, 16'hAAAA,  8'h20,  1'b0, NO_CHECK},
		'{ACT_TOP,   16'hAAAA,  8'h55,  1'b0, NO_CHECK},
		'{ACT_POP,   16'd0,     8'd0,   1'b0, NO_CHECK},
		'{ACT_POP,   16'd0,     8'd0,   1'b0, NO_CHECK},
		'{ACT_POP,   16'd0,     8'd0,   1'b0, NO_CHECK},
		'{ACT_POP,   16'd0,     8'd0,   1'b0, NO_CHECK},
		// stack drained again
		'{ACT_POP,   16'd0,     8'd0,   1'b1, '{32'd0, STS_EMPTY, 17'd0,     1'b1, 1'b0}},
		'{ACT_TOP,   16'd0,     8'd0,   1'b1, '{32'd0, STS_EMPTY, 17'd0,     1'b1, 1'b0}},
		// one block exactly fills the arena, then allocate when full
		'{ACT_ALLOC, 16'd65520, 8'd1,   1'b1, '{32'd0, STS_OK,    17'd65536, 1'b0, 1'b1}},
		'{ACT_ALLOC, 16'd0,     8'd1,   1'b1, '{32'd0, STS_FULL,  17'd65536, 1'b0, 1'b1}},
		'{ACT_TOP,   16'd0,     8'd1,   1'b1, '{32'd0, STS_OK,    17'd65536, 1'b0, 1'b1}},
		'{ACT_POP,   16'd0,     8'd1,   1'b1, '{32'd0, STS_OK,    17'd0,     1'b1, 1'b0}},
		'{ACT_ALLOC, 16'd100,   8'd16,  1'b0, NO_CHECK},
		// clear with blocks held, then clear on an empty arena
		'{ACT_CLEAR, 16'd0,     8'd0,   1'b1, '{32'd0, STS_OK,    17'd0,     1'b1, 1'b0}},
		'{ACT_CLEAR, 16'd0,     8'd0,   1'b1, '{32'd0, STS_OK,    17'd0,     1'b1, 1'b0}}
	};

	// phase 0 runs on the reset settings; later phases are entered without a
	// clear, so lowering the capacity below the used offset happens naturally
	localparam int PHASES = 6;
	localparam arena_phase_t PHASE_LIST [0:PHASES-1] = '{
		'{17'd65536,  32'h0000_0000, 250, 70, 10},
		'{17'd2048,   32'h1234_5673, 200, 55, 5},
		'{17'd0,      32'hFFFF_FFFF, 60,  50, 10},
		'{17'h1FFFF,  32'h8000_0001, 300, 75, 0},
		'{17'd300,    32'h0000_0005, 200, 55, 5},
		'{17'd65535,  32'hFFFF_FFF0, 300, 65, 8}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // block_size[15:0], alignment[23:16]
	logic [1:0]  s_tuser;   // action[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // address[31:0], status[33:32], bytes_used[50:34],
	                        // is_empty[51], is_full[52]

	aligned_stack_allocator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// arena predictor state: mirrors the registers and the header stack
	// ------------------------------------------------------------------------
	logic [16:0] cap_reg;
	logic [31:0] base_reg;
	logic [31:0] used_bytes;
	int unsigned live_blocks;
	logic [31:0] blk_size [MAX_BLOCKS];
	logic [31:0] blk_pad  [MAX_BLOCKS];
	logic [31:0] blk_hpad [MAX_BLOCKS];

	alloc_result_t pending_results[$];

	int unsigned errors;
	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned refused_allocs;
	int unsigned empty_hits;
	int unsigned deepest_stack;
	int unsigned burst_left;
	int unsigned idle_cycles;

	// works out the result of one item and advances the arena state
	function automatic alloc_result_t model_arena(input action_t act,
			input logic [15:0] sz, input logic [7:0] al);
		alloc_result_t r;
		logic [31:0]   cap;
		logic [31:0]   aw;
		logic [31:0]   a32;
		logic [31:0]   pad;
		logic [31:0]   hpad;
		logic [31:0]   span;
		logic [63:0]   sum;
		int unsigned   k;
		cap = (cap_reg > 17'(ARENA_BYTES)) ? 32'(ARENA_BYTES) : 32'(cap_reg);
		// highest set bit of the alignment, zero behaves as one
		aw = 32'd1;
		for (int i = 0; i < 8; i++) begin
			if (al[i]) aw = 32'd1 << i;
		end
		r = NO_CHECK;
		case (act)
			ACT_ALLOC: begin
				if (used_bytes == cap || live_blocks >= MAX_BLOCKS) begin
					r.status = STS_FULL;
				end else begin
					a32  = base_reg + used_bytes;
					pad  = (32'd0 - a32) & (aw - 32'd1);
					sum  = 64'(used_bytes) + 64'(pad) + 64'(sz);
					a32  = base_reg + sum[31:0];
					hpad = (32'd0 - a32) & 32'(HEADER_ALIGN - 1);
					sum  = sum + 64'(HEADER_BYTES) + 64'(hpad);
					if (sum > 64'(cap)) begin
						r.status = STS_FULL;
					end else begin
						r.address = base_reg + used_bytes + pad;
						blk_size[live_blocks] = 32'(sz);
						blk_pad[live_blocks]  = pad;
						blk_hpad[live_blocks] = hpad;
						live_blocks++;
						used_bytes = sum[31:0];
					end
				end
			end
			ACT_POP: begin
				if (live_blocks == 0 || used_bytes == 0) begin
					r.status = STS_EMPTY;
				end else begin
					k    = live_blocks - 1;
					span = blk_size[k] + blk_pad[k] + blk_hpad[k] + 32'(HEADER_BYTES);
					used_bytes  = (span > used_bytes) ? 32'd0 : used_bytes - span;
					live_blocks = k;
				end
			end
			ACT_TOP: begin
				if (live_blocks == 0) begin
					r.status = STS_EMPTY;
				end else begin
					k = live_blocks - 1;
					r.address = base_reg + used_bytes - 32'(HEADER_BYTES)
						- blk_hpad[k] - blk_size[k];
				end
			end
			default: begin
				used_bytes  = 32'd0;
				live_blocks = 0;
			end
		endcase
		r.used  = used_bytes[16:0];
		r.empty = (used_bytes == 32'd0);
		r.full  = (used_bytes == cap);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// ------------------------------------------------------------------------
	// sender: bursts of items separated by random gaps, driven on the
	// falling edge; the handshake is seen at the rising edge
	// ------------------------------------------------------------------------
	task automatic send_item(input action_t act, input logic [15:0] sz,
			input logic [7:0] al, input logic typed, input alloc_result_t want);
		alloc_result_t predicted;
		int unsigned   gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tuser  = act;
		s_tdata  = {al, sz};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		// item taken at this edge
		predicted = model_arena(act, sz, al);
		pending_results.push_back(typed ? want : predicted);
		if (predicted.status == STS_FULL) refused_allocs++;
		if (predicted.status == STS_EMPTY) empty_hits++;
		if (live_blocks > deepest_stack) deepest_stack = live_blocks;
		items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// random item with a phase-dependent mix of actions and sizes
	task automatic send_random_item(input arena_phase_t ph);
		action_t       act;
		logic [15:0]   sz;
		logic [7:0]    al;
		int unsigned   r;
		r = $urandom_range(0, 99);
		if (r < ph.alloc_pct) act = ACT_ALLOC;
		else if (r < ph.alloc_pct + (100 - ph.alloc_pct) / 2) act = ACT_POP;
		else if (r < 99) act = ACT_TOP;
		else act = ACT_CLEAR;
		r = $urandom_range(0, 99);
		if (r < ph.big_pct) sz = 16'($urandom_range(0, 65535));
		else if (r < ph.big_pct + 15) sz = 16'($urandom_range(0, 1023));
		else sz = 16'($urandom_range(0, 64));
		// mostly clean powers of two, sometimes any byte
		if ($urandom_range(0, 99) < 80) al = 8'd1 << $urandom_range(0, 7);
		else al = 8'($urandom_range(0, 255));
		send_item(act, sz, al, 1'b0, NO_CHECK);
	endtask

	// let every expected result come back and the pipeline settle
	task automatic drain_arena;
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// register write followed by a read back of the same register
	task automatic write_register(input logic [2:0] addr, input logic [31:0] value,
			input logic [31:0] readback);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = addr;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite  = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== readback) report_mismatch("register read back", prdata, readback);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// receiver: stall pattern re-chosen each time stall_tick wraps to zero
	// always ready, roughly 70 percent ready, or one cycle in eight
	// ------------------------------------------------------------------------
	logic [5:0] stall_tick;
	logic [1:0] stall_mode;

	always @(negedge clk) begin
		stall_tick = stall_tick + 6'd1;
		if (stall_tick == 6'd0) stall_mode = 2'($urandom_range(0, 2));
		case (stall_mode)
			2'd0:    m_tready = 1'b1;
			2'd1:    m_tready = ($urandom_range(0, 9) < 7);
			default: m_tready = (stall_tick[2:0] == 3'd0);
		endcase
	end

	// ------------------------------------------------------------------------
	// result checker and watchdog, both on the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result item", m_tdata[31:0], 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[31:0] !== want.address)
					report_mismatch("address", m_tdata[31:0], want.address);
				if (m_tdata[33:32] !== want.status)
					report_mismatch("status", 32'(m_tdata[33:32]), 32'(want.status));
				if (m_tdata[50:34] !== want.used)
					report_mismatch("bytes_used", 32'(m_tdata[50:34]), 32'(want.used));
				if (m_tdata[51] !== want.empty)
					report_mismatch("is_empty", 32'(m_tdata[51]), 32'(want.empty));
				if (m_tdata[52] !== want.full)
					report_mismatch("is_full", 32'(m_tdata[52]), 32'(want.full));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = 3'd0;
		pwdata     = 32'd0;
		s_tvalid   = 1'b0;
		s_tdata    = 24'd0;
		s_tuser    = ACT_ALLOC;
		m_tready   = 1'b0;
		stall_tick = 6'd0;
		stall_mode = 2'd0;
		errors         = 0;
		items_sent     = 0;
		results_seen   = 0;
		refused_allocs = 0;
		empty_hits     = 0;
		deepest_stack  = 0;
		burst_left     = 0;
		idle_cycles    = 0;
		// predictor starts from the reset settings
		cap_reg     = 17'(ARENA_BYTES);
		base_reg    = 32'd0;
		used_bytes  = 32'd0;
		live_blocks = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed list on the reset settings
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_item(DIRECTED[i].act, DIRECTED[i].size, DIRECTED[i].align,
				DIRECTED[i].typed, DIRECTED[i].want);

		// random phases; registers change only with the block drained
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain_arena();
				write_register({REG_CAPACITY, 2'b00}, 32'(PHASE_LIST[p].cap),
					32'(PHASE_LIST[p].cap));
				cap_reg = PHASE_LIST[p].cap;
				write_register({REG_BASE, 2'b00}, PHASE_LIST[p].base, PHASE_LIST[p].base);
				base_reg = PHASE_LIST[p].base;
			end
			for (int n = 0; n < PHASE_LIST[p].items; n++)
				send_random_item(PHASE_LIST[p]);
		end

		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d items in %0d register settings, %0d results compared",
			items_sent, PHASES, results_seen);
		$display("refused allocations %0d, pops or tops on empty %0d, deepest stack %0d",
			refused_allocs, empty_hits, deepest_stack);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/asau_pkg.sv
design/asau_ctrl.sv
design/asau_dp.sv
design/aligned_stack_allocator_unit.sv
verif/tb_top.sv
